// ===== src/bitmap_slot_allocator_top_macros.svh =====
`ifndef BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH
`define BITMAP_SLOT_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication, checked on clk_i while out of reset
`define BSA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bsa_pkg.sv =====
`default_nettype none

package bsa_pkg;

  localparam int MAP_BITS    = 1024;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = MAP_BITS / WORD_BITS;
  localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int SLOT_W      = 10;
  localparam int COUNT_W     = 11;
  localparam int ADDR_W      = WORD_IDX_W + 1;
  localparam int MEM_ROWS    = 2 * MAP_WORDS;
  localparam int OP_W        = 3;
  localparam int STATUS_W    = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  typedef enum logic [OP_W-1:0] {
    OP_QUERY     = 3'd0,
    OP_MARK_USED = 3'd1,
    OP_MARK_FREE = 3'd2,
    OP_FIND      = 3'd3,
    OP_ALLOC     = 3'd4
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  localparam logic [CFG_IDX_W-1:0] REG_INODE_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_SLOTS  = 2'd1;

  typedef struct packed {
    logic                 rd_en;
    logic [ADDR_W-1:0]    rd_addr;
    logic                 wr_en;
    logic [ADDR_W-1:0]    wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== src/bsa_bitmap_store.sv =====
`default_nettype none

module bsa_bitmap_store (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bsa_pkg::mem_req_t             req_i,
  output logic [bsa_pkg::WORD_BITS-1:0]      rd_data_o
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mem_q [MEM_ROWS];
  logic [MEM_ROWS-1:0]  row_vld_q;
  logic [WORD_BITS-1:0] rd_word_q;
  logic                 rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_word_q <= mem_q[req_i.rd_addr];
    end
  end

  // rows never written read as free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        row_vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q <= row_vld_q[req_i.rd_addr];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_word_q : '0;

endmodule

`default_nettype wire

// ===== src/bsa_free_finder.sv =====
`default_nettype none

module bsa_free_finder (
  input  wire logic [bsa_pkg::WORD_BITS-1:0] word_i,
  input  wire logic                          last_i,
  input  wire logic [bsa_pkg::BIT_IDX_W-1:0] tail_i,
  output logic                               found_o,
  output logic [bsa_pkg::BIT_IDX_W-1:0]      pos_o
);
  import bsa_pkg::*;

  logic [WORD_BITS-1:0] mask;
  logic [WORD_BITS-1:0] free;

  // slots past the count in the last word count as used
  always_comb begin
    if (last_i && (tail_i != '0)) begin
      mask = (WORD_BITS'(1) << tail_i) - WORD_BITS'(1);
    end else begin
      mask = '1;
    end
    free    = ~word_i & mask;
    found_o = |free;
    pos_o   = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (free[b]) begin
        pos_o = BIT_IDX_W'(b);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/bitmap_slot_allocator_top.sv =====
`default_nettype none
`include "bitmap_slot_allocator_top_macros.svh"

// Two used/free bitmaps (inode slots, data clusters) of 1024 bits each, held
// as 32-bit words in one synchronous RAM; both maps read as all free after
// reset. A request carries opcode and slot index in tdata and the map select in
// tuser, and returns one result of slot index, bit value and status. Query and
// mark go from accept to result through RAM read, modify and write back, and
// output load; a request outside the configured count, or a find or allocate
// on a map whose count is zero, skips the RAM read. Otherwise find and
// allocate read one map word per cycle from word zero, as the single RAM read
// port allows, until a free slot or the last word within the count. One
// request is in flight at a time; a result waiting in the output register does
// not hold off the next request.
module bitmap_slot_allocator_top (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // opcode [2:0], slot_index [12:3], zero [15:13]
  input  wire logic [bsa_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // map_select
  input  wire logic                            s_axis_tuser_i,
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // result_index [9:0], slot_used [10], status [12:11], zero [15:13]
  output logic [bsa_pkg::OUT_DATA_W-1:0]       m_axis_tdata_o,
  input  wire logic                            cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire logic [bsa_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [bsa_pkg::COUNT_W-1:0]     cfg_data_i
);
  import bsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  op_e    op_q, op_d;
  logic   sel_q, sel_d;
  logic [SLOT_W-1:0]     idx_q, idx_d;
  logic [WORD_IDX_W-1:0] word_q, word_d;
  logic [WORD_IDX_W-1:0] last_word_q, last_word_d;
  logic [BIT_IDX_W-1:0]  tail_q, tail_d;
  logic [SLOT_W-1:0]     res_idx_q, res_idx_d;
  logic                  res_used_q, res_used_d;
  status_e               res_status_q, res_status_d;
  logic [SLOT_W-1:0]     out_idx_q;
  logic                  out_used_q;
  status_e               out_status_q;
  logic                  out_valid_q, out_valid_d;
  logic                  out_load;
  logic [COUNT_W-1:0]    inode_cnt_q, data_cnt_q;

  logic                  in_acc;
  op_e                   op_in;
  logic [SLOT_W-1:0]     idx_in;
  logic [COUNT_W-1:0]    cnt_in;
  logic [COUNT_W-1:0]    cnt_m1;
  logic                  search_in;
  mem_req_t              mem_req;
  logic [WORD_BITS-1:0]  rd_data;
  logic                  fnd;
  logic [BIT_IDX_W-1:0]  fnd_pos;
  logic                  last_word;
  logic [BIT_IDX_W-1:0]  bit_sel;
  logic [WORD_BITS-1:0]  new_word;
  logic [COUNT_W-1:0]    cfg_eff;

  bsa_bitmap_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

  bsa_free_finder u_finder (
    .word_i  (rd_data),
    .last_i  (last_word),
    .tail_i  (tail_q),
    .found_o (fnd),
    .pos_o   (fnd_pos)
  );

  assign cfg_ready_o = 1'b1;
  assign cfg_eff = (cfg_data_i > COUNT_W'(MAP_BITS)) ? COUNT_W'(MAP_BITS) : cfg_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inode_cnt_q <= COUNT_W'(MAP_BITS);
      data_cnt_q  <= COUNT_W'(MAP_BITS);
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == REG_INODE_SLOTS) begin
        inode_cnt_q <= cfg_eff;
      end else if (cfg_index_i == REG_DATA_SLOTS) begin
        data_cnt_q <= cfg_eff;
      end
    end
  end

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc    = s_axis_tvalid_i && s_axis_tready_o;
  assign op_in     = op_e'(s_axis_tdata_i[OP_W-1:0]);
  assign idx_in    = s_axis_tdata_i[OP_W +: SLOT_W];
  assign cnt_in    = s_axis_tuser_i ? data_cnt_q : inode_cnt_q;
  assign cnt_m1    = cnt_in - COUNT_W'(1);
  assign search_in = (op_in == OP_FIND) || (op_in == OP_ALLOC);
  assign last_word = (word_q == last_word_q);
  assign bit_sel   = idx_q[BIT_IDX_W-1:0];

  always_comb begin
    case (op_q)
      OP_MARK_USED: new_word = rd_data | (WORD_BITS'(1) << bit_sel);
      OP_MARK_FREE: new_word = rd_data & ~(WORD_BITS'(1) << bit_sel);
      default:      new_word = rd_data;
    endcase
  end

  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    sel_d        = sel_q;
    idx_d        = idx_q;
    word_d       = word_q;
    last_word_d  = last_word_q;
    tail_d       = tail_q;
    res_idx_d    = res_idx_q;
    res_used_d   = res_used_q;
    res_status_d = res_status_q;
    out_load     = 1'b0;
    mem_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d        = op_in;
          sel_d       = s_axis_tuser_i;
          idx_d       = idx_in;
          last_word_d = cnt_m1[BIT_IDX_W +: WORD_IDX_W];
          tail_d      = cnt_in[BIT_IDX_W-1:0];
          res_used_d  = 1'b0;
          if (search_in) begin
            word_d = '0;
            if (cnt_in == '0) begin
              res_idx_d    = '0;
              res_status_d = ST_FULL;
              state_d      = S_PUSH;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = {s_axis_tuser_i, {WORD_IDX_W{1'b0}}};
              state_d         = S_SCAN;
            end
          end else begin
            word_d = idx_in[SLOT_W-1:BIT_IDX_W];
            if ({1'b0, idx_in} >= cnt_in) begin
              res_idx_d    = idx_in;
              res_status_d = ST_RANGE;
              state_d      = S_PUSH;
            end else begin
              mem_req.rd_en   = 1'b1;
              mem_req.rd_addr = {s_axis_tuser_i, idx_in[SLOT_W-1:BIT_IDX_W]};
              state_d         = S_SCAN;
            end
          end
        end
      end
      S_SCAN: begin
        if ((op_q == OP_FIND) || (op_q == OP_ALLOC)) begin
          if (fnd) begin
            res_idx_d    = {word_q, fnd_pos};
            res_used_d   = (op_q == OP_ALLOC);
            res_status_d = ST_OK;
            state_d      = S_PUSH;
            if (op_q == OP_ALLOC) begin
              mem_req.wr_en   = 1'b1;
              mem_req.wr_addr = {sel_q, word_q};
              mem_req.wr_data = rd_data | (WORD_BITS'(1) << fnd_pos);
            end
          end else if (last_word) begin
            res_idx_d    = '0;
            res_used_d   = 1'b0;
            res_status_d = ST_FULL;
            state_d      = S_PUSH;
          end else begin
            word_d          = word_q + WORD_IDX_W'(1);
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = {sel_q, word_d};
          end
        end else begin
          res_idx_d    = idx_q;
          res_used_d   = new_word[bit_sel];
          res_status_d = ST_OK;
          state_d      = S_PUSH;
          if ((op_q == OP_MARK_USED) || (op_q == OP_MARK_FREE)) begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = {sel_q, word_q};
            mem_req.wr_data = new_word;
          end
        end
      end
      S_PUSH: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    sel_q        <= sel_d;
    idx_q        <= idx_d;
    word_q       <= word_d;
    last_word_q  <= last_word_d;
    tail_q       <= tail_d;
    res_idx_q    <= res_idx_d;
    res_used_q   <= res_used_d;
    res_status_q <= res_status_d;
    if (out_load) begin
      out_idx_q    <= res_idx_q;
      out_used_q   <= res_used_q;
      out_status_q <= res_status_q;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = OUT_DATA_W'({out_status_q, out_used_q, out_idx_q});

  `BSA_ASSERT_NOW(a_wr_only_in_scan, mem_req.wr_en, state_q == S_SCAN, "ram write outside scan")
  `BSA_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_q != S_IDLE, "request accepted but idle")
  `BSA_ASSERT_NOW(a_out_load_from_push, out_load, state_q == S_PUSH, "result loaded outside push")
  `BSA_ASSERT_NOW(a_full_zero_index, out_valid_q && (out_status_q == ST_FULL),
                  (out_idx_q == '0) && !out_used_q, "full result with nonzero fields")

endmodule

`default_nettype wire

// ===== verif/tb_bitmap_slot_allocator_top.sv =====
`default_nettype none

module tb_bitmap_slot_allocator_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bsa_pkg::*;

  localparam int CLK_HALF    = 2;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 135;
  localparam int N_PHASES    = 8;

  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  localparam logic MAP_INODE = 1'b0;
  localparam logic MAP_DATA  = 1'b1;

  typedef struct packed {
    status_e           status;
    logic              used;
    logic [SLOT_W-1:0] slot;
  } slot_result_t;

  class slot_map_scoreboard;
    logic [MAP_BITS-1:0] bitmap [2];
    logic [COUNT_W-1:0]  count_reg [2];
    slot_result_t        pending [$];
    int                  errors;

    function new();
      bitmap[0]    = '0;
      bitmap[1]    = '0;
      count_reg[0] = 11'd1024;
      count_reg[1] = 11'd1024;
      errors       = 0;
    endfunction

    function void set_count(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      if (idx == REG_INODE_SLOTS) begin
        count_reg[0] = val;
      end else if (idx == REG_DATA_SLOTS) begin
        count_reg[1] = val;
      end
    endfunction

    function int limit(logic sel);
      return (count_reg[sel] > MAP_BITS) ? MAP_BITS : int'(count_reg[sel]);
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic sel, logic [SLOT_W-1:0] slot);
      slot_result_t r;
      int           lim;
      lim      = limit(sel);
      r.slot   = slot;
      r.used   = 1'b0;
      r.status = ST_OK;
      if (op == OP_FIND || op == OP_ALLOC) begin
        r.slot   = '0;
        r.status = ST_FULL;
        for (int i = 0; i < lim; i++) begin
          if (!bitmap[sel][i]) begin
            r.slot   = SLOT_W'(i);
            r.status = ST_OK;
            if (op == OP_ALLOC) begin
              bitmap[sel][i] = 1'b1;
              r.used         = 1'b1;
            end
            break;
          end
        end
      end else if (int'(slot) >= lim) begin
        r.status = ST_RANGE;
      end else begin
        if (op == OP_MARK_USED) begin
          bitmap[sel][slot] = 1'b1;
        end else if (op == OP_MARK_FREE) begin
          bitmap[sel][slot] = 1'b0;
        end
        r.used = bitmap[sel][slot];
      end
      pending = {pending, r};
    endfunction

    function void check_result(logic [OUT_DATA_W-1:0] tdata);
      slot_result_t got;
      slot_result_t want;
      got = slot_result_t'(tdata[12:0]);
      if (pending.size() == 0) begin
        $error("result with no request outstanding: %h", tdata);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.slot !== want.slot) begin
        $error("result_index expected %0d got %0d", want.slot, got.slot);
        errors++;
      end
      if (got.used !== want.used) begin
        $error("slot_used expected %0d got %0d", want.used, got.used);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status expected %0d got %0d", want.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid_i;
  logic                  s_axis_tready_o;
  // opcode [2:0], slot_index [12:3], zero [15:13]
  logic [IN_DATA_W-1:0]  s_axis_tdata_i;
  // map_select
  logic                  s_axis_tuser_i;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i;
  // result_index [9:0], slot_used [10], status [12:11], zero [15:13]
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [COUNT_W-1:0]    cfg_data_i;

  slot_map_scoreboard sb = new();
  int                 cycles = 0;
  int                 tx_calm = 0;
  int                 rx_calm = 0;

  int unsigned inode_set [N_PHASES] = '{8, 13, 2047, 40, 0, 1024, 1, 200};
  int unsigned data_set  [N_PHASES] = '{16, 1, 8, 2047, 24, 64, 1000, 5};

  bitmap_slot_allocator_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #(CLK_HALF) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_bitmap_slot_allocator_top NOT OK");
      $finish;
    end
  end

  // random wait per item, with occasional runs of back-to-back traffic
  function automatic int pick_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(10, 40);
    end
    return $urandom_range(0, 10);
  endfunction

  task automatic send_request(input logic [OP_W-1:0] op, input logic sel,
                              input logic [SLOT_W-1:0] slot);
    int gap;
    gap = pick_gap(tx_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {3'b000, slot, op};
    s_axis_tuser_i  <= sel;
    do @(posedge clk_i); while (!s_axis_tready_o);
    sb.note_request(op, sel, slot);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_count(idx, val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stop requests and let every outstanding result drain
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic random_phase(input int n_items);
    logic [OP_W-1:0]   op;
    logic              sel;
    logic [SLOT_W-1:0] slot;
    int                lim;
    int                pick;
    for (int k = 0; k < n_items; k++) begin
      sel  = 1'($urandom_range(0, 1));
      lim  = sb.limit(sel);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        op = OP_ALLOC;
      end else if (pick < 50) begin
        op = OP_MARK_FREE;
      end else if (pick < 62) begin
        op = OP_MARK_USED;
      end else if (pick < 76) begin
        op = OP_QUERY;
      end else if (pick < 90) begin
        op = OP_FIND;
      end else if (pick < 95) begin
        case ($urandom_range(0, 2))
          0: op = OP_SPARE_5;
          1: op = OP_SPARE_6;
          default: op = OP_SPARE_7;
        endcase
      end else begin
        op = OP_W'($urandom_range(0, 7));
      end
      pick = $urandom_range(0, 9);
      if (pick < 7 && lim > 0) begin
        slot = SLOT_W'($urandom_range(0, lim - 1));
      end else if (pick < 8) begin
        slot = (lim >= MAP_BITS) ? SLOT_W'($urandom_range(MAP_BITS - 8, MAP_BITS - 1))
                                 : SLOT_W'(lim);
      end else begin
        slot = SLOT_W'($urandom_range(0, MAP_BITS - 1));
      end
      send_request(op, sel, slot);
    end
  endtask

  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      int gap;
      gap = pick_gap(rx_calm);
      @(negedge clk_i);
      if (gap > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
      sb.check_result(m_axis_tdata_o);
    end
  end

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = 1'b0;
    cfg_valid_i     = 1'b0;
    cfg_index_i     = '0;
    cfg_data_i      = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // full-size maps straight after reset
    send_request(OP_QUERY,     MAP_INODE, 10'd0);
    send_request(OP_QUERY,     MAP_DATA,  10'd1023);
    send_request(OP_FIND,      MAP_INODE, 10'd1023);
    send_request(OP_ALLOC,     MAP_INODE, 10'd0);
    send_request(OP_ALLOC,     MAP_INODE, 10'd512);
    send_request(OP_MARK_USED, MAP_INODE, 10'd1023);
    send_request(OP_SPARE_5,   MAP_INODE, 10'd1023);
    send_request(OP_MARK_FREE, MAP_INODE, 10'd0);
    send_request(OP_FIND,      MAP_INODE, 10'd0);
    send_request(OP_ALLOC,     MAP_DATA,  10'h3ff);
    send_request(OP_SPARE_6,   MAP_DATA,  10'd0);
    send_request(OP_SPARE_7,   MAP_INODE, 10'd1);
    send_request(OP_MARK_USED, MAP_DATA,  10'h2aa);
    send_request(OP_QUERY,     MAP_DATA,  10'h155);
    send_request(OP_MARK_FREE, MAP_DATA,  10'd1023);

    // small inode count, empty data map
    settle();
    write_reg(REG_INODE_SLOTS, 11'd8);
    write_reg(REG_DATA_SLOTS,  11'd0);
    send_request(OP_QUERY,     MAP_INODE, 10'd8);
    send_request(OP_MARK_USED, MAP_INODE, 10'd1023);
    send_request(OP_MARK_USED, MAP_INODE, 10'd7);
    send_request(OP_ALLOC,     MAP_DATA,  10'd0);
    send_request(OP_FIND,      MAP_DATA,  10'd0);
    send_request(OP_QUERY,     MAP_DATA,  10'd0);
    send_request(OP_MARK_FREE, MAP_INODE, 10'd1);

    for (int p = 0; p < N_PHASES; p++) begin
      settle();
      write_reg(REG_INODE_SLOTS, COUNT_W'(inode_set[p]));
      write_reg(REG_DATA_SLOTS,  COUNT_W'(data_set[p]));
      if (p == 2) begin
        write_reg(REG_UNUSED, COUNT_W'($urandom_range(0, 2047)));
      end
      random_phase(PHASE_ITEMS);
    end

    settle();
    if (sb.errors == 0) begin
      $display("tb_bitmap_slot_allocator_top OK");
    end else begin
      $display("tb_bitmap_slot_allocator_top NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+src
src/bsa_pkg.sv
src/bsa_bitmap_store.sv
src/bsa_free_finder.sv
src/bitmap_slot_allocator_top.sv
verif/tb_bitmap_slot_allocator_top.sv
